### rtl/core/lc3_subset_instruction_step_core_assert.svh
// Assertion macros used by the LC-3 subset core RTL.
`ifndef LC3_SUBSET_INSTRUCTION_STEP_CORE_ASSERT_SVH
`define LC3_SUBSET_INSTRUCTION_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LC3S_ASSERT_IMP(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("lc3s assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LC3S_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("lc3s assertion failed");

`endif

### rtl/core/lc3s_pkg.sv
// Shared types, constants and helper functions of the LC-3 subset core.
`timescale 1ns / 1ps
`default_nettype none

package lc3s_pkg;

  localparam int MEM_WORDS = 32;
  localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int NUM_REGS  = 8;

  typedef logic [15:0] word_t;
  typedef logic [MEM_AW-1:0] mem_addr_t;
  typedef logic [NUM_REGS-1:0][15:0] rf_t;

  localparam word_t BASE_RESET = 16'h3000;
  localparam word_t PC_RESET   = 16'h3000;

  // Register file after reset: R1 = 5, R2 = 15, all others zero.
  localparam rf_t RF_RESET = {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd15, 16'd5, 16'd0};

  // Item kinds carried on the input user sideband.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_EXEC    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Supported opcodes.
  localparam logic [3:0] OP_BR  = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_ST  = 4'd3;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_JMP = 4'd12;

  // Condition flag encodings, ordered {N, Z, P}.
  localparam logic [2:0] FL_N = 3'b100;
  localparam logic [2:0] FL_Z = 3'b010;
  localparam logic [2:0] FL_P = 3'b001;

  typedef struct packed {
    logic      we;
    mem_addr_t addr;
    word_t     data;
  } mem_wr_t;

  typedef struct packed {
    word_t       pc_next;
    logic [2:0]  flags_next;
    logic        reg_we;
    logic [2:0]  reg_idx;
    word_t       reg_val;
    logic        mem_we;
    mem_addr_t   mem_idx;
    word_t       mem_data;
    mem_addr_t   ld_raddr;
    logic        ld_wait;
  } exec_ctl_t;

  typedef struct packed {
    word_t      pc_after;
    word_t      instr;
    logic       reg_write;
    logic [2:0] reg_index;
    word_t      reg_value;
    logic       mem_write;
    logic [4:0] mem_index;
    logic       flag_n;
    logic       flag_z;
    logic       flag_p;
    logic       bad_address;
  } result_t;

  function automatic word_t sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic word_t sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [2:0] flags_of(input word_t v);
    logic [2:0] f;
    if (v[15]) begin
      f = FL_N;
    end else if (v == 16'd0) begin
      f = FL_Z;
    end else begin
      f = FL_P;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lc3s_pmem.sv
// Program memory: one write port and two registered read ports with write bypass.
`timescale 1ns / 1ps
`default_nettype none

module lc3s_pmem
  import lc3s_pkg::*;
(
  input  wire logic      clk,
  input  wire mem_wr_t   wr,
  input  wire mem_addr_t fetch_raddr,
  input  wire mem_addr_t data_raddr,
  output word_t          fetch_rdata,
  output word_t          data_rdata
);

  word_t mem [MEM_WORDS];

  // A write in the same cycle as a read of the same word returns the new data.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (wr.we && (wr.addr == fetch_raddr)) begin
      fetch_rdata <= wr.data;
    end else begin
      fetch_rdata <= mem[fetch_raddr];
    end
    if (wr.we && (wr.addr == data_raddr)) begin
      data_rdata <= wr.data;
    end else begin
      data_rdata <= mem[data_raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/lc3s_exec.sv
// Decode and execute of one item against the current architectural state.
`timescale 1ns / 1ps
`default_nettype none

module lc3s_exec
  import lc3s_pkg::*;
(
  input  wire logic [1:0] kind,
  input  wire logic [4:0] load_index,
  input  wire word_t      load_data,
  input  wire word_t      pc,
  input  wire word_t      base,
  input  wire logic [2:0] flags,
  input  wire rf_t        rf,
  input  wire word_t      ibuf,
  input  wire word_t      ldbuf,
  input  wire logic       ld_fresh,
  output exec_ctl_t       ctl,
  output result_t         res
);

  localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

  logic [3:0] op;
  logic [2:0] dr;
  logic [2:0] sr1;
  word_t      fetch_off;
  logic       fetch_ok;
  word_t      pc_inc;
  word_t      data_addr;
  word_t      data_off;
  logic       data_ok;
  logic       li_ok;
  word_t      opa;
  word_t      opb;
  logic       bad;
  word_t      instr;

  assign op        = ibuf[15:12];
  assign dr        = ibuf[11:9];
  assign sr1       = ibuf[8:6];
  assign fetch_off = pc - base;
  assign fetch_ok  = {1'b0, fetch_off} < MEM_LIMIT;
  assign pc_inc    = pc + 16'd1;
  assign data_addr = pc_inc + sext9(ibuf[8:0]);
  assign data_off  = data_addr - base;
  assign data_ok   = {1'b0, data_off} < MEM_LIMIT;
  assign li_ok     = {12'd0, load_index} < MEM_LIMIT;
  assign opa       = rf[sr1];
  assign opb       = ibuf[5] ? sext5(ibuf[4:0]) : rf[ibuf[2:0]];

  always_comb begin
    ctl            = '0;
    ctl.pc_next    = pc;
    ctl.flags_next = flags;
    ctl.ld_raddr   = data_off[MEM_AW-1:0];
    bad            = 1'b0;
    instr          = 16'd0;

    unique case (kind)
      KIND_LOAD: begin
        if (li_ok) begin
          ctl.mem_we   = 1'b1;
          ctl.mem_idx  = MEM_AW'(load_index);
          ctl.mem_data = load_data;
        end else begin
          bad = 1'b1;
        end
      end
      KIND_RESTART: begin
        ctl.pc_next = base;
      end
      KIND_EXEC: begin
        if (!fetch_ok) begin
          bad = 1'b1;
        end else begin
          instr       = ibuf;
          ctl.pc_next = pc_inc;
          unique case (op)
            OP_ADD: begin
              ctl.reg_we  = 1'b1;
              ctl.reg_idx = dr;
              ctl.reg_val = opa + opb;
            end
            OP_AND: begin
              ctl.reg_we  = 1'b1;
              ctl.reg_idx = dr;
              ctl.reg_val = opa & opb;
            end
            OP_NOT: begin
              ctl.reg_we  = 1'b1;
              ctl.reg_idx = dr;
              ctl.reg_val = ~opa;
            end
            OP_LD: begin
              // The data word comes from the registered data buffer.
              ctl.ld_wait = !ld_fresh;
              if (data_ok) begin
                ctl.reg_we  = 1'b1;
                ctl.reg_idx = dr;
                ctl.reg_val = ldbuf;
              end else begin
                bad = 1'b1;
              end
            end
            OP_ST: begin
              if (data_ok) begin
                ctl.mem_we   = 1'b1;
                ctl.mem_idx  = data_off[MEM_AW-1:0];
                ctl.mem_data = rf[dr];
              end else begin
                bad = 1'b1;
              end
            end
            OP_BR: begin
              if ((ibuf[11:9] & flags) != 3'd0) begin
                ctl.pc_next = data_addr;
              end
            end
            OP_JMP: begin
              ctl.pc_next = opa;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (ctl.reg_we) begin
      ctl.flags_next = flags_of(ctl.reg_val);
    end

    res             = '0;
    res.pc_after    = ctl.pc_next;
    res.instr       = instr;
    res.reg_write   = ctl.reg_we;
    res.reg_index   = ctl.reg_idx;
    res.reg_value   = ctl.reg_val;
    res.mem_write   = ctl.mem_we && (kind == KIND_EXEC);
    res.mem_index   = res.mem_write ? 5'(ctl.mem_idx) : 5'd0;
    res.flag_n      = ctl.flags_next[2];
    res.flag_z      = ctl.flags_next[1];
    res.flag_p      = ctl.flags_next[0];
    res.bad_address = bad;
  end

endmodule

`default_nettype wire

### rtl/core/lc3_subset_instruction_step_core.sv
// Top level of the LC-3 subset core: state registers, handshakes and output register.
// Each executed item's result is registered in the output register; an LD accepted while
// the data buffer is stale (after an executed item or a base write) waits for its data.
// Throughput: one item per cycle unless the output stalls or an LD waits; then the input
// is not ready. Reset (rst, synchronous, active high) sets base and PC to 0x3000, R1 = 5,
// R2 = 15, the other registers and the flags to zero; program memory keeps no reset value.
`timescale 1ns / 1ps
`default_nettype none
`include "lc3_subset_instruction_step_core_assert.svh"

module lc3_subset_instruction_step_core
  import lc3s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: load_index [4:0], load_data [20:5], zero padding [23:21]
  input  wire logic [23:0] s_axis_tdata,
  // tuser: kind [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: pc_after [15:0], instr [31:16], reg_write [32], reg_index [35:33],
  // reg_value [51:36], mem_write [52], mem_index [57:53], flag_n [58], flag_z [59],
  // flag_p [60], bad_address [61], zero padding [63:62]
  output logic [63:0]      m_axis_tdata
);

  // Architectural state.
  word_t      base;
  word_t      pc;
  logic [2:0] flags;
  rf_t        rf;

  // The fetch buffer always holds the program word at the current PC. The data
  // buffer holds the word addressed by an LD in the fetch buffer, but only when no
  // item executed and the base was not written in the previous cycle; ld_fresh
  // tracks that. An LD transaction that arrives while it is stale is accepted and
  // held in the hold register until the output is free and the data buffer current.
  word_t      ibuf;
  word_t      ldbuf;
  logic       ld_fresh;
  logic       hold;

  logic       out_valid;
  result_t    out_res;

  logic       out_free;
  logic       s_acc;
  logic       go;
  logic [1:0] kind_eff;
  word_t      pc_n;
  word_t      base_n;
  word_t      fetch_off_n;
  mem_wr_t    mem_wr;
  exec_ctl_t  ctl;
  result_t    res;

  // The output register frees up in the same cycle its transaction completes.
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !rst && !hold && out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // A held item is always an execute.
  assign kind_eff = hold ? KIND_EXEC : s_axis_tuser;

  lc3s_exec u_exec (
    .kind       (kind_eff),
    .load_index (s_axis_tdata[4:0]),
    .load_data  (s_axis_tdata[20:5]),
    .pc         (pc),
    .base       (base),
    .flags      (flags),
    .rf         (rf),
    .ibuf       (ibuf),
    .ldbuf      (ldbuf),
    .ld_fresh   (ld_fresh),
    .ctl        (ctl),
    .res        (res)
  );

  // An item executes when accepted with its operands ready, or when the held
  // item finds the output register free and the data buffer current.
  assign go = !rst && ((s_acc && !ctl.ld_wait) || (hold && out_free && ld_fresh));

  // The fetch read follows the PC and base that hold after this edge, so the
  // fetch buffer is current in every cycle.
  assign pc_n        = rst ? PC_RESET : (go ? ctl.pc_next : pc);
  assign base_n      = rst ? BASE_RESET : (cfg_wr_en ? cfg_wr_data : base);
  assign fetch_off_n = pc_n - base_n;

  assign mem_wr.we   = go && ctl.mem_we;
  assign mem_wr.addr = ctl.mem_idx;
  assign mem_wr.data = ctl.mem_data;

  lc3s_pmem u_pmem (
    .clk         (clk),
    .wr          (mem_wr),
    .fetch_raddr (fetch_off_n[MEM_AW-1:0]),
    .data_raddr  (ctl.ld_raddr),
    .fetch_rdata (ibuf),
    .data_rdata  (ldbuf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= BASE_RESET;
      pc        <= PC_RESET;
      flags     <= 3'd0;
      rf        <= RF_RESET;
      ld_fresh  <= 1'b0;
      hold      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base <= cfg_wr_data;
      end
      if (go) begin
        pc    <= ctl.pc_next;
        flags <= ctl.flags_next;
        if (ctl.reg_we) begin
          rf[ctl.reg_idx] <= ctl.reg_val;
        end
      end
      ld_fresh <= !(go || cfg_wr_en);
      if (s_acc && ctl.ld_wait) begin
        hold <= 1'b1;
      end else if (go) begin
        hold <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset.
  always_ff @(posedge clk) begin
    if (go) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.bad_address, out_res.flag_p, out_res.flag_z,
                          out_res.flag_n, out_res.mem_index, out_res.mem_write,
                          out_res.reg_value, out_res.reg_index, out_res.reg_write,
                          out_res.instr, out_res.pc_after};

  // Every executed item leaves a result in the output register.
  `LC3S_ASSERT_NEXT(a_go_fills_out, clk, rst, go, out_valid)
  // A stalled LD parks in the hold register and blocks further input.
  `LC3S_ASSERT_NEXT(a_ld_wait_holds, clk, rst, s_acc && ctl.ld_wait, hold && !s_axis_tready)
  // Executing an item invalidates the data buffer for the next cycle.
  `LC3S_ASSERT_NEXT(a_go_stales_ld, clk, rst, go, !ld_fresh)
  // No item writes both a register and program memory.
  `LC3S_ASSERT_IMP(a_one_writeback, clk, rst, go, !(ctl.reg_we && ctl.mem_we))

endmodule

`default_nettype wire
